// File: sv/rehc_pkg.sv
// ----------------------------------------------------------------------------
// rehc_pkg
// Shared types and constants for the ring exclusion hop counter: operation
// and register codes, field widths, reset thresholds and the sequencer states.
// ----------------------------------------------------------------------------
package rehc_pkg;

  // Default sizes of the lattice and the counters
  localparam int SITES_DEF      = 16;
  localparam int PARTICLES_DEF  = 8;
  localparam int COUNT_BITS_DEF = 32;

  // Fixed widths of the item fields
  localparam int OP_W      = 2;
  localparam int SITE_W    = 4;
  localparam int PART_W    = 3;
  localparam int DRAW_W    = 16;
  localparam int THR_W     = 17;
  localparam int OUT_CNT_W = 32;
  localparam int CFG_IDX_W = 2;

  // Hop thresholds out of 65536 after reset (0.1 and 0.5, rounded)
  localparam logic [THR_W-1:0] HOP_EMPTY_RST = 17'd6554;
  localparam logic [THR_W-1:0] HOP_OCC_RST   = 17'd32768;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PLACE  = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOP_EMPTY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOP_OCC   = 2'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_MODIFY,
    ST_SECOND,
    ST_DONE
  } state_t;

  // Commands to the per-particle counter store
  typedef struct packed {
    logic clear;     // zero the row at port A address
    logic capture;   // read both rows and hold their addresses
    logic wr_en;     // write back one held row
    logic wr_sel_b;  // write back row B instead of row A
    logic bump_vis;  // add one to the visit count of that row
    logic bump_bnd;  // add one to the bond count of that row
  } pair_cmd_t;

endpackage

// File: sv/rehc_pair_store.sv
// ----------------------------------------------------------------------------
// rehc_pair_store
// Visit and bond-crossing counters, one row per particle and site, in one
// memory with two registered read ports and one write port. Rows read on a
// capture are written back later with saturating increments.
// ----------------------------------------------------------------------------
module rehc_pair_store #(
  parameter int DEPTH = rehc_pkg::PARTICLES_DEF * rehc_pkg::SITES_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = rehc_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  rehc_pkg::pair_cmd_t cmd,
  input  logic [AW-1:0]       addr_a,
  input  logic [AW-1:0]       addr_b,
  output logic [CW-1:0]       vis_a,
  output logic [CW-1:0]       bnd_a
);

  logic [2*CW-1:0] mem [DEPTH];
  logic [2*CW-1:0] q_a_r;
  logic [2*CW-1:0] q_b_r;
  logic [AW-1:0]   wa_a_r;
  logic [AW-1:0]   wa_b_r;
  logic [2*CW-1:0] row_sel;
  logic [CW-1:0]   vis_sel;
  logic [CW-1:0]   bnd_sel;
  logic [CW-1:0]   vis_new;
  logic [CW-1:0]   bnd_new;
  logic [AW-1:0]   wr_addr;

  // Read both rows and hold where they came from
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_a_r  <= mem[addr_a];
      q_b_r  <= mem[addr_b];
      wa_a_r <= addr_a;
      wa_b_r <= addr_b;
    end
  end

  // Bump the chosen row, holding each count at its maximum
  always_comb begin
    row_sel = cmd.wr_sel_b ? q_b_r : q_a_r;
    wr_addr = cmd.wr_sel_b ? wa_b_r : wa_a_r;
    vis_sel = row_sel[2*CW-1:CW];
    bnd_sel = row_sel[CW-1:0];
    vis_new = (cmd.bump_vis && (vis_sel != {CW{1'b1}})) ? vis_sel + CW'(1) : vis_sel;
    bnd_new = (cmd.bump_bnd && (bnd_sel != {CW{1'b1}})) ? bnd_sel + CW'(1) : bnd_sel;
  end

  // Clear sweep or write back
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[addr_a] <= '0;
    end else if (cmd.wr_en) begin
      mem[wr_addr] <= {vis_new, bnd_new};
    end
  end

  assign vis_a = q_a_r[2*CW-1:CW];
  assign bnd_a = q_a_r[CW-1:0];

endmodule

// File: sv/ring_exclusion_hop_counter.sv
// ----------------------------------------------------------------------------
// ring_exclusion_hop_counter
// Ring of exclusion particles with saturating visit, bond and site counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item: operation, site,
//   particle and random_draw. Operation place puts the next particle on an
//   empty site, update lets the particle on a site try to hop one site down,
//   read returns the counters of a particle and site.
//   Result channel (out_valid / out_stall) returns one item per input item,
//   in order. The result sits in an output register, so it may wait there
//   while the block takes and works on the next item.
//   Configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) sets the
//   two hop thresholds; cfg_ready is always high.
//   Each item walks a sequencer over the site memory and the counter memory:
//   accept, lookup, modify, result, with a second write step after modify
//   when a particle hops (the site memory has one write port). The result is
//   registered, and a new item is taken only once the sequencer is idle.
//   After reset the block sweeps both memories to zero, one row a cycle, over
//   all PARTICLES*SITES counter rows (128 with the defaults); in_stall is high
//   during the sweep. A stalled result holds the sequencer in its result step.
// ----------------------------------------------------------------------------
module ring_exclusion_hop_counter #(
  parameter int SITES      = rehc_pkg::SITES_DEF,
  parameter int PARTICLES  = rehc_pkg::PARTICLES_DEF,
  parameter int COUNT_BITS = rehc_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rehc_pkg::OP_W-1:0]          in_operation,
  input  logic [rehc_pkg::SITE_W-1:0]        in_site,
  input  logic [rehc_pkg::PART_W-1:0]        in_particle,
  input  logic [rehc_pkg::DRAW_W-1:0]        in_random_draw,
  // result items
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_status,
  output logic                               out_hopped,
  output logic [rehc_pkg::PART_W-1:0]        out_mover,
  output logic [rehc_pkg::SITE_W-1:0]        out_target_site,
  output logic [rehc_pkg::OUT_CNT_W-1:0]     out_visit_count,
  output logic [rehc_pkg::OUT_CNT_W-1:0]     out_bond_count,
  output logic [rehc_pkg::OUT_CNT_W-1:0]     out_site_count,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rehc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rehc_pkg::THR_W-1:0]         cfg_data
);

  localparam int CW    = COUNT_BITS;
  localparam int SW    = $clog2(SITES);
  localparam int OW    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int PLW   = $clog2(PARTICLES + 1);
  localparam int DEPTH = PARTICLES * SITES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SMW   = 1 + OW + CW;

  localparam int OUT_W = rehc_pkg::OUT_CNT_W;

  // Row address of a particle and site in the counter memory
  function automatic logic [AW-1:0] pair_addr(input logic [OW-1:0] id,
                                               input logic [SW-1:0] s);
    return AW'(32'(id) * SITES + 32'(s));
  endfunction

  rehc_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]   clr_r;
  logic            prev_occ_r;
  logic [PLW-1:0]  placed_r;
  logic [rehc_pkg::THR_W-1:0] thr_empty_r;
  logic [rehc_pkg::THR_W-1:0] thr_occ_r;

  // captured item
  logic [rehc_pkg::OP_W-1:0]   op_r;
  logic [rehc_pkg::SITE_W-1:0] site_r;
  logic [SW-1:0]               si_r;
  logic [SW-1:0]               bl_r;
  logic                        in_rng_r;
  logic [OW-1:0]               part_r;
  logic                        part_rng_r;
  logic [rehc_pkg::DRAW_W-1:0] draw_r;

  // lookup decisions
  logic            place_ok_r;
  logic            upd_occ_r;
  logic            hop_r;
  logic [OW-1:0]   id_r;
  logic            rd_ok_r;
  logic            part_ok_r;

  logic            place_ok;
  logic            upd_occ;
  logic            hop;
  logic [OW-1:0]   a_id;
  logic [rehc_pkg::THR_W-1:0] thr;

  // site memory: {occupied, owner, site visits}
  logic [SMW-1:0]  site_mem [SITES];
  logic [SMW-1:0]  sq_s_r;
  logic [SMW-1:0]  sq_b_r;
  logic            sq_occ_s;
  logic            sq_occ_b;
  logic [OW-1:0]   sq_own_s;
  logic [CW-1:0]   sq_sv_s;
  logic [CW-1:0]   sq_sv_b;
  logic [CW-1:0]   sv_s_inc;
  logic [CW-1:0]   sv_b_inc;
  logic            site_we;
  logic [SW-1:0]   site_wa;
  logic [SMW-1:0]  site_wd;

  logic [SW-1:0]   in_si;
  logic [SW-1:0]   in_bl;
  logic            in_accept;
  logic            out_load;
  logic            clr_last;

  rehc_pkg::pair_cmd_t pcmd;
  logic [AW-1:0]   pa_addr;
  logic [AW-1:0]   pb_addr;
  logic [CW-1:0]   vis_a;
  logic [CW-1:0]   bnd_a;

  logic            out_valid_r;
  logic            out_status_r;
  logic            out_hopped_r;
  logic [rehc_pkg::PART_W-1:0] out_mover_r;
  logic [rehc_pkg::SITE_W-1:0] out_target_r;
  logic [OUT_W-1:0] out_visit_r;
  logic [OUT_W-1:0] out_bond_r;
  logic [OUT_W-1:0] out_site_r;

  assign in_accept = in_valid && !in_stall;
  assign clr_last  = (clr_r == AW'(DEPTH - 1));
  assign cfg_ready = 1'b1;

  // Site index and its neighbour below on the ring
  assign in_si = SW'(in_site);
  assign in_bl = (in_si == '0) ? SW'(SITES - 1) : in_si - SW'(1);

  // Unpack site memory read data
  assign sq_occ_s = sq_s_r[SMW-1];
  assign sq_own_s = sq_s_r[CW +: OW];
  assign sq_sv_s  = sq_s_r[CW-1:0];
  assign sq_occ_b = sq_b_r[SMW-1];
  assign sq_sv_b  = sq_b_r[CW-1:0];
  assign sv_s_inc = (sq_sv_s != {CW{1'b1}}) ? sq_sv_s + CW'(1) : sq_sv_s;
  assign sv_b_inc = (sq_sv_b != {CW{1'b1}}) ? sq_sv_b + CW'(1) : sq_sv_b;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_empty_r <= rehc_pkg::HOP_EMPTY_RST;
      thr_occ_r   <= rehc_pkg::HOP_OCC_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rehc_pkg::CFG_HOP_EMPTY: thr_empty_r <= cfg_data;
        rehc_pkg::CFG_HOP_OCC:   thr_occ_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the item and read both site entries
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r       <= in_operation;
      site_r     <= in_site;
      si_r       <= in_si;
      bl_r       <= in_bl;
      in_rng_r   <= (32'(in_site) < SITES);
      part_r     <= OW'(in_particle);
      part_rng_r <= (32'(in_particle) < PARTICLES);
      draw_r     <= in_random_draw;
      sq_s_r     <= site_mem[in_si];
      sq_b_r     <= site_mem[in_bl];
    end
  end

  // Site memory write port
  always_ff @(posedge clk) begin
    if (site_we) begin
      site_mem[site_wa] <= site_wd;
    end
  end

  // Decide the move from the site entries
  always_comb begin
    thr      = prev_occ_r ? thr_occ_r : thr_empty_r;
    place_ok = (op_r == rehc_pkg::OP_PLACE) && in_rng_r && !sq_occ_s &&
               (32'(placed_r) < PARTICLES);
    upd_occ  = (op_r == rehc_pkg::OP_UPDATE) && in_rng_r && sq_occ_s;
    hop      = upd_occ && !sq_occ_b && ({1'b0, draw_r} < thr);
    case (op_r)
      rehc_pkg::OP_PLACE: a_id = OW'(placed_r);
      rehc_pkg::OP_READ:  a_id = part_r;
      default:            a_id = sq_own_s;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == rehc_pkg::ST_LOOKUP) begin
      place_ok_r <= place_ok;
      upd_occ_r  <= upd_occ;
      hop_r      <= hop;
      id_r       <= place_ok ? OW'(placed_r) : sq_own_s;
      rd_ok_r    <= (op_r == rehc_pkg::OP_READ) && in_rng_r;
      part_ok_r  <= (op_r == rehc_pkg::OP_READ) && in_rng_r && part_rng_r;
    end
  end

  // Counter rows: the chosen particle at the site (A) and at the site below (B)
  assign pa_addr = (state_r == rehc_pkg::ST_CLEAR) ? clr_r : pair_addr(a_id, si_r);
  assign pb_addr = pair_addr(sq_own_s, bl_r);

  rehc_pair_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_pair_store (
    .clk    (clk),
    .cmd    (pcmd),
    .addr_a (pa_addr),
    .addr_b (pb_addr),
    .vis_a  (vis_a),
    .bnd_a  (bnd_a)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rehc_pkg::ST_CLEAR:  if (clr_last) state_nxt = rehc_pkg::ST_IDLE;
      rehc_pkg::ST_IDLE:   if (in_valid) state_nxt = rehc_pkg::ST_LOOKUP;
      rehc_pkg::ST_LOOKUP: state_nxt = rehc_pkg::ST_MODIFY;
      rehc_pkg::ST_MODIFY: state_nxt = hop_r ? rehc_pkg::ST_SECOND : rehc_pkg::ST_DONE;
      rehc_pkg::ST_SECOND: state_nxt = rehc_pkg::ST_DONE;
      rehc_pkg::ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = rehc_pkg::ST_IDLE;
      default:             state_nxt = rehc_pkg::ST_CLEAR;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    pcmd     = '0;
    site_we  = 1'b0;
    site_wa  = si_r;
    site_wd  = {1'b1, id_r, sv_s_inc};
    unique case (state_r)
      rehc_pkg::ST_CLEAR: begin
        pcmd.clear = 1'b1;
        site_we    = (32'(clr_r) < SITES);
        site_wa    = SW'(clr_r);
        site_wd    = '0;
      end
      rehc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      rehc_pkg::ST_LOOKUP: begin
        pcmd.capture = 1'b1;
      end
      rehc_pkg::ST_MODIFY: begin
        // first writes: the site, or on a hop its bond count and the site below
        pcmd.wr_en    = place_ok_r || upd_occ_r;
        pcmd.bump_vis = place_ok_r || (upd_occ_r && !hop_r);
        pcmd.bump_bnd = hop_r;
        site_we       = place_ok_r || upd_occ_r;
        if (hop_r) begin
          site_wa = bl_r;
          site_wd = {1'b1, id_r, sv_b_inc};
        end
      end
      rehc_pkg::ST_SECOND: begin
        // vacate the site and count the arrival below
        pcmd.wr_en    = 1'b1;
        pcmd.wr_sel_b = 1'b1;
        pcmd.bump_vis = 1'b1;
        site_we       = 1'b1;
        site_wd       = {1'b0, id_r, sq_sv_s};
      end
      rehc_pkg::ST_DONE: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rehc_pkg::ST_CLEAR;
      clr_r      <= '0;
      prev_occ_r <= 1'b0;
      placed_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == rehc_pkg::ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (state_r == rehc_pkg::ST_MODIFY) begin
        if ((op_r == rehc_pkg::OP_UPDATE) && in_rng_r) begin
          prev_occ_r <= upd_occ_r;
        end
        if (place_ok_r) begin
          placed_r <= placed_r + PLW'(1);
        end
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= (op_r == rehc_pkg::OP_PLACE) && !place_ok_r;
      out_hopped_r <= hop_r;
      out_mover_r  <= (place_ok_r || upd_occ_r) ? rehc_pkg::PART_W'(id_r) : '0;
      if (place_ok_r || (upd_occ_r && !hop_r)) begin
        out_target_r <= site_r;
      end else if (hop_r) begin
        out_target_r <= rehc_pkg::SITE_W'(bl_r);
      end else begin
        out_target_r <= '0;
      end
      out_visit_r <= part_ok_r ? OUT_W'(vis_a) : '0;
      out_bond_r  <= part_ok_r ? OUT_W'(bnd_a) : '0;
      out_site_r  <= rd_ok_r ? OUT_W'(sq_sv_s) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_hopped      = out_hopped_r;
  assign out_mover       = out_mover_r;
  assign out_target_site = out_target_r;
  assign out_visit_count = out_visit_r;
  assign out_bond_count  = out_bond_r;
  assign out_site_count  = out_site_r;

`ifndef NO_ASSERTIONS
  // No item is taken while the memories are being swept
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rehc_pkg::ST_CLEAR) |-> in_stall)
    else $error("item accepted during clear sweep");

  // A hop only lands on a site that was empty
  a_hop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rehc_pkg::ST_MODIFY && hop_r) |-> !sq_occ_b)
    else $error("hop onto occupied site");

  // A bond count moves only with a hop
  a_bond_hop: assert property (@(posedge clk) disable iff (!rst_n)
    (pcmd.wr_en && pcmd.bump_bnd) |-> (hop_r && upd_occ_r))
    else $error("bond count bumped without a hop");

  // Never more particles placed than exist
  a_placed: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(placed_r) <= PARTICLES))
    else $error("placed count beyond particle count");
`endif

endmodule

// File: verif/ring_exclusion_hop_counter_test.sv
// ----------------------------------------------------------------------------
// ring_exclusion_hop_counter_test
// Self-checking bench for the ring exclusion hop counter. A directed sequence
// places particles, walks them round the wrap of the ring, probes the hop
// threshold on either side and reads back the counters. Random phases then run
// under several threshold settings, including never-hop and always-hop. Every
// result is checked field by field against a lattice model kept in the bench,
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module ring_exclusion_hop_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rehc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic                           status;
    logic                           hopped;
    logic [rehc_pkg::PART_W-1:0]    mover;
    logic [rehc_pkg::SITE_W-1:0]    target_site;
    logic [rehc_pkg::OUT_CNT_W-1:0] visit_count;
    logic [rehc_pkg::OUT_CNT_W-1:0] bond_count;
    logic [rehc_pkg::OUT_CNT_W-1:0] site_count;
  } lattice_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [rehc_pkg::OP_W-1:0]      in_operation = rehc_pkg::OP_PLACE;
  logic [rehc_pkg::SITE_W-1:0]    in_site = '0;
  logic [rehc_pkg::PART_W-1:0]    in_particle = '0;
  logic [rehc_pkg::DRAW_W-1:0]    in_random_draw = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_status;
  logic                           out_hopped;
  logic [rehc_pkg::PART_W-1:0]    out_mover;
  logic [rehc_pkg::SITE_W-1:0]    out_target_site;
  logic [rehc_pkg::OUT_CNT_W-1:0] out_visit_count;
  logic [rehc_pkg::OUT_CNT_W-1:0] out_bond_count;
  logic [rehc_pkg::OUT_CNT_W-1:0] out_site_count;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rehc_pkg::CFG_IDX_W-1:0] cfg_index = rehc_pkg::CFG_HOP_EMPTY;
  logic [rehc_pkg::THR_W-1:0]     cfg_data = '0;

  ring_exclusion_hop_counter u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_site         (in_site),
    .in_particle     (in_particle),
    .in_random_draw  (in_random_draw),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_hopped      (out_hopped),
    .out_mover       (out_mover),
    .out_target_site (out_target_site),
    .out_visit_count (out_visit_count),
    .out_bond_count  (out_bond_count),
    .out_site_count  (out_site_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2ns clk = ~clk;

  // Lattice model state, cleared as at reset
  logic                           lat_occupied [rehc_pkg::SITES_DEF] = '{default: 1'b0};
  logic [rehc_pkg::PART_W-1:0]    lat_owner [rehc_pkg::SITES_DEF] = '{default: '0};
  logic [rehc_pkg::OUT_CNT_W-1:0] lat_visits [rehc_pkg::PARTICLES_DEF][rehc_pkg::SITES_DEF] =
                                    '{default: '{default: '0}};
  logic [rehc_pkg::OUT_CNT_W-1:0] lat_bonds [rehc_pkg::PARTICLES_DEF][rehc_pkg::SITES_DEF] =
                                    '{default: '{default: '0}};
  logic [rehc_pkg::OUT_CNT_W-1:0] lat_site_visits [rehc_pkg::SITES_DEF] = '{default: '0};
  logic                           lat_prev_occupied = 1'b0;
  int                             lat_placed = 0;
  logic [rehc_pkg::THR_W-1:0]     thr_after_empty = rehc_pkg::HOP_EMPTY_RST;
  logic [rehc_pkg::THR_W-1:0]     thr_after_occupied = rehc_pkg::HOP_OCC_RST;

  lattice_result_t pending_results [$];
  int errors = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit steady = 1'b0;

  // Run statistics for the summary
  int n_items = 0;
  int n_placed_ok = 0;
  int n_placed_rej = 0;
  int n_updates = 0;
  int n_hops = 0;
  int n_reads = 0;
  int n_settings = 1;

  function automatic logic [rehc_pkg::OUT_CNT_W-1:0] sat_inc(
      logic [rehc_pkg::OUT_CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Advance the lattice by one item and return the result it should give
  function automatic lattice_result_t advance_lattice(logic [rehc_pkg::OP_W-1:0] op,
                                                      logic [rehc_pkg::SITE_W-1:0] site,
                                                      logic [rehc_pkg::PART_W-1:0] part,
                                                      logic [rehc_pkg::DRAW_W-1:0] draw);
    lattice_result_t             res;
    logic [rehc_pkg::PART_W-1:0] id;
    logic [rehc_pkg::SITE_W-1:0] below;
    logic [rehc_pkg::THR_W-1:0]  thr;
    res = '0;
    case (op)
      rehc_pkg::OP_PLACE: begin
        if (lat_occupied[site] || lat_placed >= rehc_pkg::PARTICLES_DEF) begin
          res.status = 1'b1;
          n_placed_rej++;
        end else begin
          id = rehc_pkg::PART_W'(lat_placed);
          lat_occupied[site] = 1'b1;
          lat_owner[site] = id;
          lat_visits[id][site] = sat_inc(lat_visits[id][site]);
          lat_site_visits[site] = sat_inc(lat_site_visits[site]);
          lat_placed++;
          res.mover = id;
          res.target_site = site;
          n_placed_ok++;
        end
      end
      rehc_pkg::OP_UPDATE: begin
        n_updates++;
        if (lat_occupied[site]) begin
          id = lat_owner[site];
          below = site - 1'b1;
          thr = lat_prev_occupied ? thr_after_occupied : thr_after_empty;
          res.mover = id;
          if (!lat_occupied[below] && {1'b0, draw} < thr) begin
            lat_occupied[site] = 1'b0;
            lat_occupied[below] = 1'b1;
            lat_owner[below] = id;
            lat_visits[id][below] = sat_inc(lat_visits[id][below]);
            lat_bonds[id][site] = sat_inc(lat_bonds[id][site]);
            lat_site_visits[below] = sat_inc(lat_site_visits[below]);
            res.hopped = 1'b1;
            res.target_site = below;
            n_hops++;
          end else begin
            lat_visits[id][site] = sat_inc(lat_visits[id][site]);
            lat_site_visits[site] = sat_inc(lat_site_visits[site]);
            res.target_site = site;
          end
          lat_prev_occupied = 1'b1;
        end else begin
          lat_prev_occupied = 1'b0;
        end
      end
      rehc_pkg::OP_READ: begin
        n_reads++;
        res.visit_count = lat_visits[part][site];
        res.bond_count = lat_bonds[part][site];
        res.site_count = lat_site_visits[site];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Favour occupied sites so that updates and reads mostly do real work
  function automatic logic [rehc_pkg::SITE_W-1:0] pick_site();
    logic [rehc_pkg::SITE_W-1:0] s;
    s = rehc_pkg::SITE_W'($urandom_range(0, rehc_pkg::SITES_DEF - 1));
    if ($urandom_range(0, 9) < 7) begin
      for (int k = 0; k < rehc_pkg::SITES_DEF; k++) begin
        if (lat_occupied[s]) break;
        s = s + 1'b1;
      end
    end
    return s;
  endfunction

  // Send one item, wait for it to be taken and record its result
  task automatic send_item(input logic [rehc_pkg::OP_W-1:0] op,
                           input logic [rehc_pkg::SITE_W-1:0] site,
                           input logic [rehc_pkg::PART_W-1:0] part,
                           input logic [rehc_pkg::DRAW_W-1:0] draw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_site        <= site;
    in_particle    <= part;
    in_random_draw <= draw;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(advance_lattice(op, site, part, draw));
    n_items++;
  endtask

  // Drop valid and hold until every result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write both hop thresholds back to back
  task automatic set_thresholds(input logic [rehc_pkg::THR_W-1:0] after_empty,
                                input logic [rehc_pkg::THR_W-1:0] after_occupied);
    cfg_valid <= 1'b1;
    cfg_index <= rehc_pkg::CFG_HOP_EMPTY;
    cfg_data  <= after_empty;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    thr_after_empty = after_empty;
    cfg_index <= rehc_pkg::CFG_HOP_OCC;
    cfg_data  <= after_occupied;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    thr_after_occupied = after_occupied;
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Random items: mostly updates and reads, some places and unused codes
  task automatic run_random(input int count);
    int roll;
    logic [rehc_pkg::OP_W-1:0]   op;
    logic [rehc_pkg::SITE_W-1:0] site;
    logic [rehc_pkg::PART_W-1:0] part;
    logic [rehc_pkg::DRAW_W-1:0] draw;
    logic [rehc_pkg::THR_W-1:0]  thr;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      site = rehc_pkg::SITE_W'($urandom_range(0, rehc_pkg::SITES_DEF - 1));
      part = rehc_pkg::PART_W'($urandom_range(0, rehc_pkg::PARTICLES_DEF - 1));
      draw = rehc_pkg::DRAW_W'($urandom);
      if (roll < 4) begin
        op = rehc_pkg::OP_PLACE;
      end else if (roll < 8) begin
        op = OP_UNUSED;
      end else if (roll < 40) begin
        op = rehc_pkg::OP_READ;
        site = pick_site();
        if ($urandom_range(0, 1) == 0) part = lat_owner[site];
      end else begin
        op = rehc_pkg::OP_UPDATE;
        site = pick_site();
        thr = lat_prev_occupied ? thr_after_occupied : thr_after_empty;
        // probe just either side of the threshold now and then
        if ($urandom_range(0, 3) == 0 && thr != 0 && thr < 17'd65536)
          draw = rehc_pkg::DRAW_W'(thr - 1'b1 + $urandom_range(0, 1));
      end
      send_item(op, site, part, draw);
    end
    wait_for_results();
  endtask

  // Placement, rejects, wrap at site zero, threshold edges, reads, unused code
  task automatic test_directed();
    send_item(rehc_pkg::OP_PLACE, 4'd0, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_PLACE, 4'd0, 3'd7, 16'hFFFF);
    send_item(rehc_pkg::OP_PLACE, 4'd15, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_UPDATE, 4'd0, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_UPDATE, 4'd4, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_UPDATE, 4'd15, 3'd0, 16'd6554);
    send_item(rehc_pkg::OP_UPDATE, 4'd4, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_UPDATE, 4'd15, 3'd0, 16'd6553);
    send_item(rehc_pkg::OP_UPDATE, 4'd0, 3'd0, 16'd32768);
    send_item(rehc_pkg::OP_UPDATE, 4'd0, 3'd0, 16'd32767);
    send_item(rehc_pkg::OP_UPDATE, 4'd15, 3'd0, 16'hFFFF);
    send_item(rehc_pkg::OP_READ, 4'd0, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_READ, 4'd15, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_READ, 4'd14, 3'd1, 16'h0000);
    send_item(rehc_pkg::OP_READ, 4'd15, 3'd7, 16'hFFFF);
    send_item(OP_UNUSED, 4'd15, 3'd7, 16'hFFFF);
    send_item(rehc_pkg::OP_PLACE, 4'd3, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_PLACE, 4'd6, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_PLACE, 4'd9, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_PLACE, 4'd12, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_PLACE, 4'd8, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_PLACE, 4'd10, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_PLACE, 4'd1, 3'd0, 16'h0000);
    send_item(rehc_pkg::OP_READ, 4'd10, 3'd7, 16'h0000);
    send_item(rehc_pkg::OP_UPDATE, 4'd10, 3'd5, 16'h0000);
    wait_for_results();
  endtask

  task automatic test_never_hop();
    set_thresholds('0, '0);
    run_random(60);
  endtask

  // Back-to-back items with no stalls while every free hop is taken
  task automatic test_always_hop();
    set_thresholds(17'd65536, 17'd65536);
    steady = 1'b1;
    run_random(80);
    steady = 1'b0;
  endtask

  task automatic test_wide_threshold();
    set_thresholds('1, '0);
    run_random(60);
  endtask

  task automatic test_random_thresholds();
    for (int r = 0; r < 3; r++) begin
      set_thresholds(rehc_pkg::THR_W'($urandom_range(0, 65536)),
                     rehc_pkg::THR_W'($urandom_range(0, 65536)));
      run_random(80);
    end
  endtask

  task automatic test_default_thresholds();
    set_thresholds(rehc_pkg::HOP_EMPTY_RST, rehc_pkg::HOP_OCC_RST);
    run_random(100);
  endtask

  // Receiver stalls: mostly short, a few long, none in steady stretches
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                 : $urandom_range(9, 34);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic compare_field(input string name,
                               input logic [rehc_pkg::OUT_CNT_W-1:0] want,
                               input logic [rehc_pkg::OUT_CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Check each taken result against the oldest expectation
  always @(posedge clk) begin
    lattice_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, out_status);
        compare_field("hopped", want.hopped, out_hopped);
        compare_field("mover", want.mover, out_mover);
        compare_field("target_site", want.target_site, out_target_site);
        compare_field("visit_count", want.visit_count, out_visit_count);
        compare_field("bond_count", want.bond_count, out_bond_count);
        compare_field("site_count", want.site_count, out_site_count);
      end
    end
  end

  // Count cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("ring_exclusion_hop_counter_test NOT OK");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_never_hop();
    test_always_hop();
    test_wide_threshold();
    test_random_thresholds();
    test_default_thresholds();
    repeat (12) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end
    $display("ran %0d items under %0d threshold settings: %0d placed, %0d places refused",
             n_items, n_settings, n_placed_ok, n_placed_rej);
    $display("%0d updates with %0d hops, %0d counter reads, %0d errors",
             n_updates, n_hops, n_reads, errors);
    if (errors == 0)
      $display("ring_exclusion_hop_counter_test OK");
    else
      $display("ring_exclusion_hop_counter_test NOT OK");
    $finish;
  end

endmodule

// File: files.f
sv/rehc_pkg.sv
sv/rehc_pair_store.sv
sv/ring_exclusion_hop_counter.sv
verif/ring_exclusion_hop_counter_test.sv
